// ===== src/assert_macros.svh =====
// Assertion macros shared by the magnetometer min/max calibration RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define MMC_ASSERT_AT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
// condition that must never be seen outside reset
`define MMC_ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) else $error(msg);
`else
`define MMC_ASSERT_AT(lbl, clk_i, rstn_i, prop, msg)
`define MMC_ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg)
`endif
`endif

// ===== src/mmc_pkg.sv =====
// Shared types and constants for the magnetometer min/max calibration core.
// Used by every module under src; depends on nothing.
`default_nettype none

package mmc_pkg;

	localparam int AXES    = 3;
	localparam int AX_W    = 2;
	localparam int RAW_W   = 16;
	localparam int CNT_W   = 16;
	localparam int GAIN_W  = 24;
	localparam int BIAS_W  = 40;
	localparam int SCALE_W = 24;
	localparam int SUM_W   = 18;
	localparam int FRAC_W  = 16;

	// APB register map
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_RUN_LENGTH = 2'd0;
	localparam logic [1:0] REG_GAIN_X     = 2'd1;
	localparam logic [1:0] REG_GAIN_Y     = 2'd2;
	localparam logic [1:0] REG_GAIN_Z     = 2'd3;

	localparam logic [CNT_W-1:0]  RUN_LENGTH_RST = 16'd1024;
	localparam logic [GAIN_W-1:0] GAIN_RST       = 24'd50332;
	localparam logic [RAW_W-1:0]  MIN_RST        = 16'h7FFF;
	localparam logic [RAW_W-1:0]  MAX_RST        = 16'h8001;

	localparam logic [SCALE_W-1:0] SCALE_MAX = 24'h7FFFFF;
	localparam logic [SCALE_W-1:0] SCALE_MIN = 24'h800000;

	// divider: |S| * 2^16 over 3*|h|
	localparam int QUOT_W     = 33;
	localparam int DIVISOR_W  = 17;
	localparam int DIV_CNT_W  = 6;

	// item queue
	localparam int QCNT_W = 2;
	localparam logic [QCNT_W-1:0] QDEPTH = 2'd2;

	typedef struct packed {
		logic                           take;
		logic                           load;
		logic                           last;
		logic [AXES-1:0][RAW_W-1:0]     raw;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic                  start;
		logic [QUOT_W-1:0]     dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [QUOT_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== src/magnetometer_minmax_calibration_core.sv =====
// Top level of the magnetometer min/max (hard/soft iron) calibration core.
// Holds the APB registers; depends on mmc_pkg, mmc_front, mmc_fifo, mmc_back, mmc_div.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   data_ready, overflow, x_raw, y_raw, z_raw
// out       output     out_valid / out_ready bias_x/y/z, scale_x/y/z, zero_range
// apb       input      psel, penable, pready paddr, pwrite, pwdata, prdata
//
// Ordinary item: the front queues it, the back applies it; the queue drains one per cycle
// while the back is in its run state. Run end: take, operand latch, then a multiply and
// a divide per axis, then result post; a zero half-range axis skips its divide.
// Reset loads the store values at once, with no clearing pass.
// The front accepts until the queue fills; a pending result holds up the next run's end.
`default_nettype none
`include "assert_macros.svh"

module magnetometer_minmax_calibration_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [mmc_pkg::ADDR_W-1:0]           paddr,
	input  wire logic [mmc_pkg::DATA_W-1:0]           pwdata,
	output logic [mmc_pkg::DATA_W-1:0]                prdata,
	output logic                                      pready,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 data_ready,
	input  wire logic                                 overflow,
	input  wire logic signed [mmc_pkg::RAW_W-1:0]     x_raw,
	input  wire logic signed [mmc_pkg::RAW_W-1:0]     y_raw,
	input  wire logic signed [mmc_pkg::RAW_W-1:0]     z_raw,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [mmc_pkg::BIAS_W-1:0]         bias_x,
	output logic signed [mmc_pkg::BIAS_W-1:0]         bias_y,
	output logic signed [mmc_pkg::BIAS_W-1:0]         bias_z,
	output logic signed [mmc_pkg::SCALE_W-1:0]        scale_x,
	output logic signed [mmc_pkg::SCALE_W-1:0]        scale_y,
	output logic signed [mmc_pkg::SCALE_W-1:0]        scale_z,
	output logic                                      zero_range
);

	logic [mmc_pkg::CNT_W-1:0]                          run_length_q;
	logic [mmc_pkg::AXES-1:0][mmc_pkg::GAIN_W-1:0]      gain_q;
	logic [1:0]                                         reg_idx;
	logic                                               reg_wr;

	logic                                               q_push;
	logic                                               q_pop;
	mmc_pkg::entry_t                                    q_in;
	mmc_pkg::entry_t                                    q_head;
	mmc_pkg::q_stat_t                                   q_stat;
	mmc_pkg::div_req_t                                  div_req;
	mmc_pkg::div_rsp_t                                  div_rsp;
	logic [mmc_pkg::AXES-1:0][mmc_pkg::BIAS_W-1:0]      bias;
	logic [mmc_pkg::AXES-1:0][mmc_pkg::SCALE_W-1:0]     scale;

	// APB register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[mmc_pkg::ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= mmc_pkg::RUN_LENGTH_RST;
			for (int a = 0; a < mmc_pkg::AXES; a++)
				gain_q[a] <= mmc_pkg::GAIN_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				mmc_pkg::REG_RUN_LENGTH: run_length_q <= pwdata[mmc_pkg::CNT_W-1:0];
				mmc_pkg::REG_GAIN_X:     gain_q[0] <= pwdata[mmc_pkg::GAIN_W-1:0];
				mmc_pkg::REG_GAIN_Y:     gain_q[1] <= pwdata[mmc_pkg::GAIN_W-1:0];
				mmc_pkg::REG_GAIN_Z:     gain_q[2] <= pwdata[mmc_pkg::GAIN_W-1:0];
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (reg_idx)
			mmc_pkg::REG_RUN_LENGTH:
				prdata = {{(mmc_pkg::DATA_W-mmc_pkg::CNT_W){1'b0}}, run_length_q};
			mmc_pkg::REG_GAIN_X:
				prdata = {{(mmc_pkg::DATA_W-mmc_pkg::GAIN_W){1'b0}}, gain_q[0]};
			mmc_pkg::REG_GAIN_Y:
				prdata = {{(mmc_pkg::DATA_W-mmc_pkg::GAIN_W){1'b0}}, gain_q[1]};
			mmc_pkg::REG_GAIN_Z:
				prdata = {{(mmc_pkg::DATA_W-mmc_pkg::GAIN_W){1'b0}}, gain_q[2]};
		endcase
	end

	mmc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_ready   (data_ready),
		.overflow     (overflow),
		.x_raw        (x_raw),
		.y_raw        (y_raw),
		.z_raw        (z_raw),
		.run_length   (run_length_q),
		.q_stat       (q_stat),
		.push         (q_push),
		.entry        (q_in)
	);

	mmc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	mmc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_entry    (q_head),
		.q_stat     (q_stat),
		.q_pop      (q_pop),
		.gain       (gain_q),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.bias       (bias),
		.scale      (scale),
		.zero_range (zero_range)
	);

	mmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// result fields
	assign bias_x  = bias[0];
	assign bias_y  = bias[1];
	assign bias_z  = bias[2];
	assign scale_x = scale[0];
	assign scale_y = scale[1];
	assign scale_z = scale[2];

	// internal consistency checks
	`MMC_ASSERT_NEVER(a_queue_overflow, clk, arst_n, q_push && q_stat.full, "queue overflow")
	`MMC_ASSERT_NEVER(a_queue_underflow, clk, arst_n, q_pop && q_stat.empty, "queue underflow")
	`MMC_ASSERT_NEVER(a_div_restart, clk, arst_n, div_req.start && div_rsp.busy, "divider restart")
	`MMC_ASSERT_AT(a_div_done_pulse, clk, arst_n, div_rsp.done |=> !div_rsp.done, "done held")

endmodule

`default_nettype wire

// ===== src/mmc_fifo.sv =====
// Two-entry queue between the front (item intake) and back (store update).
// Depends on mmc_pkg for entry_t and q_stat_t.
`default_nettype none

module mmc_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mmc_pkg::entry_t push_entry,
	input  wire logic            pop,
	output mmc_pkg::entry_t      head,
	output mmc_pkg::q_stat_t     stat
);

	mmc_pkg::entry_t                   mem_q [2];
	logic                              wr_ptr_q;
	logic                              rd_ptr_q;
	logic [mmc_pkg::QCNT_W-1:0]        cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == mmc_pkg::QDEPTH);
	assign stat.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ===== src/mmc_front.sv =====
// Front end: accepts samples, counts items in the run, tags the run's last item.
// Depends on mmc_pkg; feeds mmc_fifo.
`default_nettype none

module mmc_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         data_ready,
	input  wire logic                         overflow,
	input  wire logic signed [mmc_pkg::RAW_W-1:0] x_raw,
	input  wire logic signed [mmc_pkg::RAW_W-1:0] y_raw,
	input  wire logic signed [mmc_pkg::RAW_W-1:0] z_raw,
	input  wire logic [mmc_pkg::CNT_W-1:0]    run_length,
	input  wire mmc_pkg::q_stat_t             q_stat,
	output logic                              push,
	output mmc_pkg::entry_t                   entry
);

	logic [mmc_pkg::CNT_W-1:0] seen_q;
	logic [mmc_pkg::CNT_W:0]   seen_nxt;
	logic                      run_end;

	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	// a count of zero behaves as one: the first item already reaches it
	assign seen_nxt = {1'b0, seen_q} + 1'b1;
	assign run_end  = (seen_nxt >= {1'b0, run_length});

	// classify the item for the back end
	always_comb begin
		entry.take   = data_ready;
		entry.load   = data_ready && !overflow;
		entry.last   = run_end;
		entry.raw[0] = x_raw;
		entry.raw[1] = y_raw;
		entry.raw[2] = z_raw;
	end

	// items seen in the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (push) begin
			if (run_end)
				seen_q <= '0;
			else
				seen_q <= seen_nxt[mmc_pkg::CNT_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== src/mmc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mmc_pkg for div_req_t and div_rsp_t.
`default_nettype none

module mmc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mmc_pkg::div_req_t req,
	output mmc_pkg::div_rsp_t      rsp
);

	logic                               busy_q;
	logic                               done_q;
	logic [mmc_pkg::DIV_CNT_W-1:0]      cnt_q;
	logic [mmc_pkg::QUOT_W-1:0]         num_q;
	logic [mmc_pkg::DIVISOR_W-1:0]      rem_q;
	logic [mmc_pkg::DIVISOR_W-1:0]      dvs_q;
	logic [mmc_pkg::DIVISOR_W:0]        trial;
	logic [mmc_pkg::DIVISOR_W:0]        diff;
	logic                               fits;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, num_q[mmc_pkg::QUOT_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= mmc_pkg::DIV_CNT_W'(mmc_pkg::QUOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mmc_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			num_q <= {num_q[mmc_pkg::QUOT_W-2:0], fits};
			rem_q <= fits ? diff[mmc_pkg::DIVISOR_W-1:0] : trial[mmc_pkg::DIVISOR_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

`default_nettype wire

// ===== src/mmc_back.sv =====
// Back end: held reading and min/max store, end-of-run sequencer, result register.
// Depends on mmc_pkg; drains mmc_fifo and drives mmc_div.
`default_nettype none

module mmc_back (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire mmc_pkg::entry_t                            q_entry,
	input  wire mmc_pkg::q_stat_t                           q_stat,
	output logic                                            q_pop,
	input  wire logic [mmc_pkg::AXES-1:0][mmc_pkg::GAIN_W-1:0] gain,
	output mmc_pkg::div_req_t                               div_req,
	input  wire mmc_pkg::div_rsp_t                          div_rsp,
	input  wire logic                                       out_ready,
	output logic                                            out_valid,
	output logic [mmc_pkg::AXES-1:0][mmc_pkg::BIAS_W-1:0]   bias,
	output logic [mmc_pkg::AXES-1:0][mmc_pkg::SCALE_W-1:0]  scale,
	output logic                                            zero_range
);

	localparam int RW = mmc_pkg::RAW_W;

	localparam logic [2:0] ST_RUN  = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]                                      state_q;
	logic [mmc_pkg::AX_W-1:0]                        ax_q;
	logic [mmc_pkg::AXES-1:0][RW-1:0]                held_q, min_q, max_q;
	logic [mmc_pkg::AXES-1:0][RW-1:0]                b_q, h_q;
	logic [mmc_pkg::SUM_W-1:0]                       total_q;
	logic [mmc_pkg::AXES-1:0][mmc_pkg::BIAS_W-1:0]   bias_q;
	logic [mmc_pkg::AXES-1:0][mmc_pkg::SCALE_W-1:0]  scale_q;
	logic                                            zero_q;
	logic                                            out_valid_q;

	logic [mmc_pkg::AXES-1:0][RW-1:0]                samp;
	logic [mmc_pkg::AXES-1:0][RW-1:0]                b_n, h_n;
	logic [RW:0]                                     sum17, dif17, sum_r, dif_r;
	logic [mmc_pkg::SUM_W-1:0]                       total_n;
	logic signed [mmc_pkg::BIAS_W:0]                 prod;
	logic [RW-1:0]                                   h_cur;
	logic [RW-1:0]                                   h_mag;
	logic [mmc_pkg::SUM_W-1:0]                       s_mag;
	logic                                            h_zero;
	logic                                            q_neg;
	logic                                            last_ax;
	logic                                            out_ok;
	logic [mmc_pkg::QUOT_W-1:0]                      quot;
	logic [mmc_pkg::SCALE_W-1:0]                     quot_neg;
	logic [mmc_pkg::SCALE_W-1:0]                     scale_sat;

	// sample value each axis compares against: new raw or the held reading
	always_comb begin
		for (int a = 0; a < mmc_pkg::AXES; a++)
			samp[a] = q_entry.load ? q_entry.raw[a] : held_q[a];
	end

	// midpoint and half-range per axis, both rounded toward zero
	always_comb begin
		total_n = '0;
		sum17   = '0;
		dif17   = '0;
		sum_r   = '0;
		dif_r   = '0;
		for (int a = 0; a < mmc_pkg::AXES; a++) begin
			sum17   = {max_q[a][RW-1], max_q[a]} + {min_q[a][RW-1], min_q[a]};
			dif17   = {max_q[a][RW-1], max_q[a]} - {min_q[a][RW-1], min_q[a]};
			sum_r   = sum17 + {{RW{1'b0}}, sum17[RW]};
			dif_r   = dif17 + {{RW{1'b0}}, dif17[RW]};
			b_n[a]  = sum_r[RW:1];
			h_n[a]  = dif_r[RW:1];
			total_n = total_n + {{(mmc_pkg::SUM_W-RW){h_n[a][RW-1]}}, h_n[a]};
		end
	end

	// per-axis datapath of the sequencer
	assign prod    = $signed(b_q[ax_q]) * $signed({1'b0, gain[ax_q]});
	assign h_cur   = h_q[ax_q];
	assign h_zero  = (h_cur == '0);
	assign h_mag   = h_cur[RW-1] ? (~h_cur + 1'b1) : h_cur;
	assign s_mag   = total_q[mmc_pkg::SUM_W-1] ? (~total_q + 1'b1) : total_q;
	assign q_neg   = total_q[mmc_pkg::SUM_W-1] ^ h_cur[RW-1];
	assign last_ax = (ax_q == mmc_pkg::AX_W'(mmc_pkg::AXES - 1));
	assign out_ok  = !out_valid_q || out_ready;

	assign div_req.start    = (state_q == ST_MUL) && !h_zero;
	assign div_req.dividend = {s_mag[mmc_pkg::QUOT_W-mmc_pkg::FRAC_W-1:0],
		{mmc_pkg::FRAC_W{1'b0}}};
	assign div_req.divisor  = {h_mag, 1'b0} + {1'b0, h_mag};

	// signed Q7.16 result with saturation
	assign quot     = div_rsp.quotient;
	assign quot_neg = ~quot[mmc_pkg::SCALE_W-1:0] + 1'b1;
	always_comb begin
		if (q_neg) begin
			if (quot > mmc_pkg::QUOT_W'(24'h800000))
				scale_sat = mmc_pkg::SCALE_MIN;
			else
				scale_sat = quot_neg;
		end else begin
			if (quot > mmc_pkg::QUOT_W'(24'h7FFFFF))
				scale_sat = mmc_pkg::SCALE_MAX;
			else
				scale_sat = quot[mmc_pkg::SCALE_W-1:0];
		end
	end

	assign q_pop = (state_q == ST_RUN) && !q_stat.empty;

	// sequencer and calibration store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			ax_q        <= '0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int a = 0; a < mmc_pkg::AXES; a++) begin
				held_q[a] <= '0;
				min_q[a]  <= mmc_pkg::MIN_RST;
				max_q[a]  <= mmc_pkg::MAX_RST;
			end
		end else begin
			if (state_q == ST_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_RUN: begin
					if (!q_stat.empty) begin
						for (int a = 0; a < mmc_pkg::AXES; a++) begin
							if (q_entry.load)
								held_q[a] <= samp[a];
							if (q_entry.take) begin
								if ($signed(samp[a]) > $signed(max_q[a]))
									max_q[a] <= samp[a];
								if ($signed(samp[a]) < $signed(min_q[a]))
									min_q[a] <= samp[a];
							end
						end
						if (q_entry.last)
							state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					// wait for the previous result to leave the output register
					if (out_ok) begin
						ax_q    <= '0;
						zero_q  <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (h_zero) begin
						zero_q <= 1'b1;
						if (last_ax)
							state_q <= ST_OUT;
						else
							ax_q <= ax_q + 1'b1;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (last_ax) begin
							state_q <= ST_OUT;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_OUT: begin
					// result goes out, store clears for the next run
					for (int a = 0; a < mmc_pkg::AXES; a++) begin
						held_q[a] <= '0;
						min_q[a]  <= mmc_pkg::MIN_RST;
						max_q[a]  <= mmc_pkg::MAX_RST;
					end
					state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// end-of-run operands and result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP && out_ok) begin
			b_q     <= b_n;
			h_q     <= h_n;
			total_q <= total_n;
		end
		if (state_q == ST_MUL) begin
			bias_q[ax_q] <= prod[mmc_pkg::BIAS_W-1:0];
			if (h_zero)
				scale_q[ax_q] <= total_q[mmc_pkg::SUM_W-1] ? mmc_pkg::SCALE_MIN
					: mmc_pkg::SCALE_MAX;
		end
		if (state_q == ST_DIV && div_rsp.done)
			scale_q[ax_q] <= scale_sat;
	end

	assign out_valid  = out_valid_q;
	assign bias       = bias_q;
	assign scale      = scale_q;
	assign zero_range = zero_q;

endmodule

`default_nettype wire
